@@ hw/rtl/sparse_set_slot_table_assert.svh @@
// assertion macros for the sparse set slot table
`ifndef SPARSE_SET_SLOT_TABLE_ASSERT_SVH
`define SPARSE_SET_SLOT_TABLE_ASSERT_SVH

// property checked at every clock edge outside reset
`define SSST_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// same-cycle implication
`define SSST_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define SSST_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hw/rtl/ssst_pkg.sv @@
// shared constants and types of the sparse set slot table
package ssst_pkg;

  localparam int unsigned MAX_KEYS    = 4096;
  localparam int unsigned MAX_ENTRIES = 1024;
  localparam int unsigned ENTRY_BITS  = 32;

  localparam int unsigned KEY_IDX_W = $clog2(MAX_KEYS);
  localparam int unsigned SLOT_W    = $clog2(MAX_ENTRIES);
  localparam int unsigned CNT_W     = $clog2(MAX_ENTRIES + 1);

  localparam int unsigned REQ_W     = 2;
  localparam int unsigned KEY_W     = 16;
  localparam int unsigned WDATA_W   = 32;
  localparam int unsigned STATUS_W  = 3;
  localparam int unsigned SLOT_F_W  = 10;
  localparam int unsigned RDATA_W   = 32;
  localparam int unsigned TOTAL_W   = 11;

  typedef enum logic [REQ_W-1:0] {
    REQ_INSERT = 2'd0,
    REQ_REMOVE = 2'd1,
    REQ_LOOKUP = 2'd2,
    REQ_CLEAR  = 2'd3
  } req_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK      = 3'd0,
    ST_PRESENT = 3'd1,
    ST_ABSENT  = 3'd2,
    ST_RANGE   = 3'd3,
    ST_FULL    = 3'd4
  } status_e;

  typedef struct packed {
    logic capture;
    logic rd_slot;
    logic commit;
  } ctrl_cmd_t;

  typedef struct packed {
    logic out_free;
  } dp_status_t;

endpackage

@@ hw/rtl/ssst_if.sv @@
// request and response channel interfaces
interface ssst_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  req_type;
  logic [15:0] key;
  logic [31:0] write_data;

  modport source (output valid, output req_type, output key, output write_data,
                  input ready);
  modport sink (input valid, input req_type, input key, input write_data,
                output ready);
endinterface

interface ssst_rsp_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic [9:0]  slot;
  logic [31:0] read_data;
  logic [10:0] entry_total;

  modport source (output valid, output status, output slot, output read_data,
                  output entry_total, input ready);
  modport sink (input valid, input status, input slot, input read_data,
                input entry_total, output ready);
endinterface

@@ hw/rtl/ssst_ctrl.sv @@
// request sequencer of the sparse set slot table
module ssst_ctrl
  import ssst_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       req_valid_i,
  output logic       req_ready_o,
  input  dp_status_t status_i,
  output ctrl_cmd_t  cmd_o
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SLOT = 2'd1;
  localparam logic [1:0] S_EXEC = 2'd2;

  logic [1:0] state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      S_IDLE: begin
        if (req_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = S_SLOT;
        end
      end
      S_SLOT: begin
        cmd_o.rd_slot = 1'b1;
        state_d       = S_EXEC;
      end
      S_EXEC: begin
        if (status_i.out_free) begin
          cmd_o.commit = 1'b1;
          state_d      = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  assign req_ready_o = (state_q == S_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

@@ hw/rtl/ssst_datapath.sv @@
// key map, slot stores, live count and result register
module ssst_datapath
  import ssst_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  ctrl_cmd_t           cmd_i,
  output dp_status_t          status_o,
  input  logic [REQ_W-1:0]    req_type_i,
  input  logic [KEY_W-1:0]    key_i,
  input  logic [WDATA_W-1:0]  write_data_i,
  output logic                rsp_valid_o,
  input  logic                rsp_ready_i,
  output logic [STATUS_W-1:0] rsp_status_o,
  output logic [SLOT_F_W-1:0] rsp_slot_o,
  output logic [RDATA_W-1:0]  rsp_read_data_o,
  output logic [TOTAL_W-1:0]  rsp_entry_total_o
);

  `include "sparse_set_slot_table_assert.svh"

  logic [SLOT_W-1:0]     k2s_mem  [MAX_KEYS];
  logic [KEY_IDX_W-1:0]  s2k_mem  [MAX_ENTRIES];
  logic [ENTRY_BITS-1:0] data_mem [MAX_ENTRIES];

  req_e                  req_q;
  logic [KEY_W-1:0]      key_q;
  logic [ENTRY_BITS-1:0] wd_q;
  logic [SLOT_W-1:0]     map_q;
  logic [KEY_IDX_W-1:0]  hit_key_q, last_key_q;
  logic [ENTRY_BITS-1:0] hit_data_q, last_data_q;
  logic [CNT_W-1:0]      count_q, count_d;

  logic                  out_valid_q;
  status_e               out_status_q;
  logic [SLOT_F_W-1:0]   out_slot_q;
  logic [RDATA_W-1:0]    out_rdata_q;
  logic [TOTAL_W-1:0]    out_total_q;

  logic [SLOT_W-1:0]     last_idx;
  logic [KEY_IDX_W-1:0]  key_idx;
  logic                  in_range, member, full;
  status_e               res_status;
  logic [SLOT_W-1:0]     res_slot;
  logic [ENTRY_BITS-1:0] res_data;

  logic                  k2s_we, s2k_we;
  logic [KEY_IDX_W-1:0]  k2s_waddr;
  logic [SLOT_W-1:0]     k2s_wdata;
  logic [SLOT_W-1:0]     slot_waddr;
  logic [KEY_IDX_W-1:0]  s2k_wdata;
  logic [ENTRY_BITS-1:0] data_wdata;

  assign last_idx = SLOT_W'(count_q - CNT_W'(1));
  assign key_idx  = key_q[KEY_IDX_W-1:0];
  assign in_range = 32'(key_q) < MAX_KEYS;
  assign member   = ({1'b0, map_q} < CNT_W'(count_q)) && (hit_key_q == key_idx);
  assign full     = (count_q == CNT_W'(MAX_ENTRIES));

  always_comb begin
    count_d    = count_q;
    res_status = ST_OK;
    res_slot   = '0;
    res_data   = '0;
    k2s_we     = 1'b0;
    s2k_we     = 1'b0;
    k2s_waddr  = key_idx;
    k2s_wdata  = SLOT_W'(count_q);
    slot_waddr = SLOT_W'(count_q);
    s2k_wdata  = key_idx;
    data_wdata = wd_q;
    case (req_q)
      REQ_CLEAR: begin
        count_d = '0;
      end
      REQ_INSERT: begin
        if (!in_range) begin
          res_status = ST_RANGE;
        end else if (member) begin
          res_status = ST_PRESENT;
        end else if (full) begin
          res_status = ST_FULL;
        end else begin
          k2s_we   = 1'b1;
          s2k_we   = 1'b1;
          res_slot = SLOT_W'(count_q);
          count_d  = count_q + CNT_W'(1);
        end
      end
      REQ_REMOVE: begin
        if (!in_range) begin
          res_status = ST_RANGE;
        end else if (member) begin
          // move the last entry into the freed slot and repoint its key
          k2s_we     = 1'b1;
          s2k_we     = 1'b1;
          k2s_waddr  = last_key_q;
          k2s_wdata  = map_q;
          slot_waddr = map_q;
          s2k_wdata  = last_key_q;
          data_wdata = last_data_q;
          res_slot   = map_q;
          count_d    = count_q - CNT_W'(1);
        end else begin
          res_status = ST_ABSENT;
        end
      end
      REQ_LOOKUP: begin
        if (!in_range) begin
          res_status = ST_RANGE;
        end else if (member) begin
          res_slot = map_q;
          res_data = hit_data_q;
        end else begin
          res_status = ST_ABSENT;
        end
      end
      default: res_status = ST_OK;
    endcase
  end

  assign status_o.out_free = !out_valid_q || rsp_ready_i;

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit && k2s_we) begin
      k2s_mem[k2s_waddr] <= k2s_wdata;
    end
    if (cmd_i.capture) begin
      map_q <= k2s_mem[key_i[KEY_IDX_W-1:0]];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit && s2k_we) begin
      s2k_mem[slot_waddr]  <= s2k_wdata;
      data_mem[slot_waddr] <= data_wdata;
    end
    if (cmd_i.rd_slot) begin
      hit_key_q   <= s2k_mem[map_q];
      last_key_q  <= s2k_mem[last_idx];
      hit_data_q  <= data_mem[map_q];
      last_data_q <= data_mem[last_idx];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      req_q <= req_e'(req_type_i);
      key_q <= key_i;
      wd_q  <= ENTRY_BITS'(write_data_i);
    end
    if (cmd_i.commit) begin
      out_status_q <= res_status;
      out_slot_q   <= SLOT_F_W'(res_slot);
      out_rdata_q  <= RDATA_W'(res_data);
      out_total_q  <= TOTAL_W'(count_d);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.commit) begin
        count_q     <= count_d;
        out_valid_q <= 1'b1;
      end else if (rsp_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign rsp_valid_o       = out_valid_q;
  assign rsp_status_o      = out_status_q;
  assign rsp_slot_o        = out_slot_q;
  assign rsp_read_data_o   = out_rdata_q;
  assign rsp_entry_total_o = out_total_q;

  `SSST_ASSERT(a_count_bound, count_q <= CNT_W'(MAX_ENTRIES), "live count above capacity")
  `SSST_ASSERT_IMP(a_commit_free, cmd_i.commit, !out_valid_q || rsp_ready_i, "result overwritten")
  `SSST_ASSERT_NXT(a_count_hold, !cmd_i.commit, $stable(count_q), "count moved without commit")
  `SSST_ASSERT_NXT(a_commit_valid, cmd_i.commit, out_valid_q, "committed result not shown")

endmodule

@@ hw/rtl/sparse_set_slot_table.sv @@
// top level of the sparse set slot table
// Each request is accepted only while the sequencer is idle; on its way to the result,
// the capture reads the key-to-slot map, the slot step reads the key and data of the
// hit slot and of the last slot (two read ports on the slot stores), and the execute
// step checks membership, writes the memories and loads the result register. A result
// not yet taken stalls the execute step. The memories have no reset and need no
// clearing pass: a key counts as a member only when its mapped slot is below the live
// count and that slot holds the key, so the block is ready right after reset.
module sparse_set_slot_table
  import ssst_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  ssst_req_if.sink   req_i,
  ssst_rsp_if.source rsp_o
);

  ctrl_cmd_t  cmd;
  dp_status_t dp_status;
  logic       req_ready;

  ssst_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_i.valid),
    .req_ready_o (req_ready),
    .status_i    (dp_status),
    .cmd_o       (cmd)
  );

  assign req_i.ready = req_ready;

  ssst_datapath u_datapath (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_i             (cmd),
    .status_o          (dp_status),
    .req_type_i        (req_i.req_type),
    .key_i             (req_i.key),
    .write_data_i      (req_i.write_data),
    .rsp_valid_o       (rsp_o.valid),
    .rsp_ready_i       (rsp_o.ready),
    .rsp_status_o      (rsp_o.status),
    .rsp_slot_o        (rsp_o.slot),
    .rsp_read_data_o   (rsp_o.read_data),
    .rsp_entry_total_o (rsp_o.entry_total)
  );

endmodule
